// ----- src/disparity_height_heatmap_assert.svh -----
// Assertion macros shared by the disparity height heatmap RTL
`ifndef DISPARITY_HEIGHT_HEATMAP_ASSERT_SVH
`define DISPARITY_HEIGHT_HEATMAP_ASSERT_SVH

// Condition that holds at every clock edge outside reset
`define DHH_ASSERT(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Same-cycle implication
`define DHH_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ----- src/dhh_pkg.sv -----
// Package: constants, codes and types of the disparity height heatmap
package dhh_pkg;

   // rows at or above the limit are clamped to the last row
   localparam int ROW_LIMIT = 4096;

   localparam int HEIGHT_W = 24;
   localparam int LEVEL_W  = 15;

   localparam logic signed [HEIGHT_W-1:0] HEIGHT_MAX = 24'sh7FFFFF;
   localparam logic signed [HEIGHT_W-1:0] HEIGHT_MIN = 24'sh800000;
   localparam logic [LEVEL_W-1:0]         LEVEL_FULL = 15'd25600;

   // operation codes
   localparam logic [1:0] OP_FRAME   = 2'd0;
   localparam logic [1:0] OP_MEASURE = 2'd1;
   localparam logic [1:0] OP_COLOR   = 2'd2;

   // status codes
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NULL     = 2'd1;
   localparam logic [1:0] ST_ZERO_DEN = 2'd2;
   localparam logic [1:0] ST_FLAT     = 2'd3;

   // register indexes
   localparam logic [1:0] CSR_ROW_OFFSET = 2'd0;
   localparam logic [1:0] CSR_WEIGHT     = 2'd1;
   localparam logic [1:0] CSR_DEPTH      = 2'd2;

   localparam logic signed [16:0] ROW_OFFSET_RST = 17'sd0;
   localparam logic signed [31:0] WEIGHT_RST     = -32'sd16777216;
   localparam logic signed [31:0] DEPTH_RST      = 32'sd0;

   // shared restoring divider
   localparam int DIV_REM_W = 42;
   localparam int DIV_DEN_W = 41;
   localparam int DIV_LOW_W = 24;
   localparam int DIV_CNT_W = 5;

   localparam logic [DIV_CNT_W-1:0] HDIV_STEPS = 5'd24;
   localparam logic [DIV_CNT_W-1:0] LDIV_STEPS = 5'd15;

   // 5243 / 2^19 approximates 1/100, exact for inputs up to 25500
   localparam logic [12:0] RECIP_100 = 13'd5243;

   typedef struct packed {
      logic                 start;
      logic [DIV_CNT_W-1:0] steps;
   } div_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

// ----- src/dhh_div.sv -----
// Shared restoring divider: one quotient bit per cycle
`include "disparity_height_heatmap_assert.svh"

module dhh_div
   import dhh_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  div_cmd_type          cmd,
   input  logic [DIV_REM_W-1:0] rem_init,
   input  logic [DIV_LOW_W-1:0] low_init,
   input  logic [DIV_DEN_W-1:0] divisor,
   output div_stat_type         stat,
   output logic [DIV_LOW_W-1:0] quotient
);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_REM_W-1:0] rem_ff, rem_in;
   logic [DIV_LOW_W-1:0] low_ff, low_in;
   logic [DIV_DEN_W-1:0] div_ff, div_in;
   logic [DIV_LOW_W-1:0] quo_ff, quo_in;

   logic [DIV_REM_W-1:0] trial;
   logic                 ge;

   // shift in next dividend bit, subtract when it fits
   assign trial = {rem_ff[DIV_REM_W-2:0], low_ff[DIV_LOW_W-1]};
   assign ge    = trial >= {1'b0, div_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      low_in  = low_ff;
      div_in  = div_ff;
      quo_in  = quo_ff;
      if (cmd.start) begin
         busy_in = 1'b1;
         cnt_in  = cmd.steps;
         rem_in  = rem_init;
         low_in  = low_init;
         div_in  = divisor;
         quo_in  = '0;
      end else if (busy_ff) begin
         rem_in = ge ? trial - {1'b0, div_ff} : trial;
         low_in = {low_ff[DIV_LOW_W-2:0], 1'b0};
         quo_in = {quo_ff[DIV_LOW_W-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      low_ff <= low_in;
      div_ff <= div_in;
      quo_ff <= quo_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = quo_ff;

   `DHH_ASSERT_IMPLY(a_no_restart, clock, reset, cmd.start, !busy_ff, "divider restarted while busy")
   `DHH_ASSERT_IMPLY(a_rem_bound, clock, reset, busy_ff, rem_ff < {1'b0, div_ff}, "partial remainder not below divisor")
   `DHH_ASSERT_IMPLY(a_done_after_busy, clock, reset, done_ff, $past(busy_ff) && !busy_ff, "done without a finishing step")

endmodule

// ----- src/dhh_ramp.sv -----
// Three-stage hue ramp: level to BGR color
module dhh_ramp
   import dhh_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [LEVEL_W-1:0] level,
   output logic               done,
   output logic [7:0]         blue,
   output logic [7:0]         green,
   output logic [7:0]         red
);

   localparam logic [17:0] SEG1 = 18'(LEVEL_FULL);
   localparam logic [17:0] SEG2 = 18'(2 * LEVEL_FULL);
   localparam logic [17:0] SEG3 = 18'(3 * LEVEL_FULL);
   localparam logic [17:0] SEG4 = 18'(4 * LEVEL_FULL);
   localparam logic [17:0] SEG5 = 18'(5 * LEVEL_FULL);

   logic               s1_v_ff, s1_v_in;
   logic               s2_v_ff, s2_v_in;
   logic               done_ff, done_in;
   logic [2:0]         seg1_ff, seg1_in;
   logic [LEVEL_W-1:0] f_ff, f_in;
   logic               blk1_ff, blk1_in;
   logic [2:0]         seg2_ff, seg2_in;
   logic [LEVEL_W-1:0] y_ff, y_in;
   logic               blk2_ff, blk2_in;
   logic [7:0]         blue_ff, blue_in;
   logic [7:0]         green_ff, green_in;
   logic [7:0]         red_ff, red_in;

   logic [LEVEL_W-1:0] diff;
   logic [17:0]        t;
   logic [17:0]        base;
   logic [LEVEL_W-1:0] fsel;
   logic [22:0]        f255;
   logic [27:0]        m3;
   logic [7:0]         x;

   // stage 1: t = 6 * (full - level), split into segment and offset
   always_comb begin
      diff = LEVEL_FULL - level;
      t    = ({3'b0, diff} << 2) + ({3'b0, diff} << 1);
      priority if (t >= SEG5) begin
         seg1_in = 3'd5;
         base    = SEG5;
      end else if (t >= SEG4) begin
         seg1_in = 3'd4;
         base    = SEG4;
      end else if (t >= SEG3) begin
         seg1_in = 3'd3;
         base    = SEG3;
      end else if (t >= SEG2) begin
         seg1_in = 3'd2;
         base    = SEG2;
      end else if (t >= SEG1) begin
         seg1_in = 3'd1;
         base    = SEG1;
      end else begin
         seg1_in = 3'd0;
         base    = '0;
      end
      f_in    = LEVEL_W'(t - base);
      blk1_in = (level == '0);
      s1_v_in = start;
   end

   // stage 2: y = floor(fsel * 255 / 256), odd segments run downhill
   always_comb begin
      fsel    = seg1_ff[0] ? LEVEL_FULL - f_ff : f_ff;
      f255    = {fsel, 8'b0} - 23'(fsel);
      y_in    = f255[22:8];
      seg2_in = seg1_ff;
      blk2_in = blk1_ff;
      s2_v_in = s1_v_ff;
   end

   // stage 3: x = y / 100 by reciprocal, then segment colors
   always_comb begin
      m3       = 28'(y_ff) * 28'(RECIP_100);
      x        = m3[26:19];
      done_in  = s2_v_ff;
      blue_in  = blue_ff;
      green_in = green_ff;
      red_in   = red_ff;
      if (s2_v_ff) begin
         unique case (seg2_ff)
            3'd0: begin
               blue_in = 8'hFF; green_in = x;     red_in = 8'h00;
            end
            3'd1: begin
               blue_in = x;     green_in = 8'hFF; red_in = 8'h00;
            end
            3'd2: begin
               blue_in = 8'h00; green_in = 8'hFF; red_in = x;
            end
            3'd3: begin
               blue_in = 8'h00; green_in = x;     red_in = 8'hFF;
            end
            3'd4: begin
               blue_in = x;     green_in = 8'h00; red_in = 8'hFF;
            end
            default: begin
               blue_in = 8'hFF; green_in = 8'h00; red_in = x;
            end
         endcase
         if (blk2_ff) begin
            blue_in  = 8'h00;
            green_in = 8'h00;
            red_in   = 8'h00;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         s1_v_ff <= s1_v_in;
         s2_v_ff <= s2_v_in;
         done_ff <= done_in;
      end
      seg1_ff  <= seg1_in;
      f_ff     <= f_in;
      blk1_ff  <= blk1_in;
      seg2_ff  <= seg2_in;
      y_ff     <= y_in;
      blk2_ff  <= blk2_in;
      blue_ff  <= blue_in;
      green_ff <= green_in;
      red_ff   <= red_in;
   end

   assign done  = done_ff;
   assign blue  = blue_ff;
   assign green = green_ff;
   assign red   = red_ff;

endmodule

// ----- src/disparity_height_heatmap.sv -----
// Top level: disparity to height reprojection with min/max tracking and hue ramp
// Each request is one pixel: a disparity byte and its image row, plus an operation
// (frame start, measure, color). Height = -(row + row_offset) / (depth_offset -
// disparity * disparity_weight) in fixed point, saturated to 24 bits with 8 fraction
// bits. Measure requests widen the frame's min/max height; color requests rescale
// the height onto 0..100 between those extremes and map it onto a BGR hue ramp.
// One request is handled at a time and req_ready is high only while the sequencer
// is idle. Frame start (or the unused operation) goes straight to the response;
// measure and color spend nearly all their time in the single shared restoring
// divider, one quotient bit per cycle: 24 bits for the height and 15 bits for the
// level; the color ramp adds a 3-stage pipeline. A finished response sits in an
// output register, so the next request can be taken while the previous response
// still waits for rsp_ready. Configuration writes are always accepted and must
// only happen while no request is in flight.
`include "disparity_height_heatmap_assert.svh"

module disparity_height_heatmap
   import dhh_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   // request channel
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [1:0]                 req_operation,
   input  logic [7:0]                 req_disparity,
   input  logic [11:0]                req_row,
   // response channel
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [HEIGHT_W-1:0] rsp_height,
   output logic [LEVEL_W-1:0]         rsp_level,
   output logic [7:0]                 rsp_blue,
   output logic [7:0]                 rsp_green,
   output logic [7:0]                 rsp_red,
   output logic [1:0]                 rsp_status,
   // register writes
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [1:0]                 csr_index,
   input  logic [31:0]                csr_data
);

   // sequencer states
   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_PREP   = 4'd1;   // numerator and product
   localparam logic [3:0] S_DEN    = 4'd2;   // denominator, launch height divide
   localparam logic [3:0] S_HDIV   = 4'd3;
   localparam logic [3:0] S_HFIN   = 4'd4;   // saturate height, track extremes
   localparam logic [3:0] S_LVL    = 4'd5;   // range checks, n * 25600
   localparam logic [3:0] S_LSTART = 4'd6;
   localparam logic [3:0] S_LDIV   = 4'd7;
   localparam logic [3:0] S_RSTART = 4'd8;
   localparam logic [3:0] S_RAMP   = 4'd9;
   localparam logic [3:0] S_DONE   = 4'd10;

   logic [3:0] state_ff, state_in;

   // configuration
   logic signed [16:0] row_offset_ff, row_offset_in;
   logic signed [31:0] weight_ff, weight_in;
   logic signed [31:0] depth_ff, depth_in;

   // frame extremes
   logic signed [HEIGHT_W-1:0] min_ff, min_in;
   logic signed [HEIGHT_W-1:0] max_ff, max_in;

   // request fields
   logic [1:0]  op_ff, op_in;
   logic [7:0]  disp_ff, disp_in;
   logic [11:0] row_ff, row_in;

   // datapath
   logic signed [17:0]         num_ff, num_in;
   logic signed [40:0]         prod_ff, prod_in;
   logic                       dzero_ff, dzero_in;
   logic                       ovf_ff, ovf_in;
   logic                       hneg_ff, hneg_in;
   logic signed [HEIGHT_W-1:0] h_ff, h_in;
   logic [1:0]                 status_ff, status_in;
   logic [LEVEL_W-1:0]         level_ff, level_in;
   logic [38:0]                p_ff, p_in;
   logic [23:0]                range_ff, range_in;
   logic [7:0]                 blue_ff, blue_in;
   logic [7:0]                 green_ff, green_in;
   logic [7:0]                 red_ff, red_in;

   // output register
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [HEIGHT_W-1:0] rsp_height_ff, rsp_height_in;
   logic [LEVEL_W-1:0]         rsp_level_ff, rsp_level_in;
   logic [7:0]                 rsp_blue_ff, rsp_blue_in;
   logic [7:0]                 rsp_green_ff, rsp_green_in;
   logic [7:0]                 rsp_red_ff, rsp_red_in;
   logic [1:0]                 rsp_status_ff, rsp_status_in;

   // combinational helpers
   logic               req_fire;
   logic               rsp_free;
   logic [16:0]        row_ext;
   logic signed [41:0] den_w;
   logic [41:0]        md_w;
   logic [17:0]        mn_w;
   logic signed [24:0] n_w;
   logic [24:0]        range_w;
   logic [23:0]        q;

   // divider and ramp hookup
   div_cmd_type          div_cmd;
   div_stat_type         div_stat;
   logic [DIV_REM_W-1:0] div_rem_init;
   logic [DIV_LOW_W-1:0] div_low_init;
   logic [DIV_DEN_W-1:0] div_divisor;
   logic [DIV_LOW_W-1:0] div_quo;
   logic                 ramp_done;
   logic [7:0]           ramp_blue, ramp_green, ramp_red;

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign q         = div_quo;

   // denominator magnitude and overflow precheck: quotient >= 2^24 when
   // (|num| << 4) >= |den|
   always_comb begin
      den_w = 42'(depth_ff) - 42'(prod_ff);
      md_w  = den_w[41] ? 42'(-den_w) : 42'(den_w);
      mn_w  = num_ff[17] ? 18'(-num_ff) : 18'(num_ff);
      n_w     = 25'(h_ff) - 25'(min_ff);
      range_w = 25'(max_ff) - 25'(min_ff);
   end

   // divider operands: height divide from S_DEN, level divide from S_LSTART
   always_comb begin
      div_cmd.start = 1'b0;
      div_cmd.steps = HDIV_STEPS;
      div_rem_init  = {21'd0, mn_w[16:0], 4'd0};
      div_low_init  = '0;
      div_divisor   = md_w[DIV_DEN_W-1:0];
      if (state_ff == S_LSTART) begin
         div_cmd.start = 1'b1;
         div_cmd.steps = LDIV_STEPS;
         div_rem_init  = {18'd0, p_ff[38:15]};
         div_low_init  = {p_ff[14:0], 9'd0};
         div_divisor   = {17'd0, range_ff};
      end else if (state_ff == S_DEN) begin
         div_cmd.start = (disp_ff != '0) && (md_w != '0) &&
                         ({20'd0, mn_w[16:0], 4'd0} < md_w[40:0]);
      end
   end

   always_comb begin
      state_in      = state_ff;
      row_offset_in = row_offset_ff;
      weight_in     = weight_ff;
      depth_in      = depth_ff;
      min_in        = min_ff;
      max_in        = max_ff;
      op_in         = op_ff;
      disp_in       = disp_ff;
      row_in        = row_ff;
      num_in        = num_ff;
      prod_in       = prod_ff;
      dzero_in      = dzero_ff;
      ovf_in        = ovf_ff;
      hneg_in       = hneg_ff;
      h_in          = h_ff;
      status_in     = status_ff;
      level_in      = level_ff;
      p_in          = p_ff;
      range_in      = range_ff;
      blue_in       = blue_ff;
      green_in      = green_ff;
      red_in        = red_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_height_in = rsp_height_ff;
      rsp_level_in  = rsp_level_ff;
      rsp_blue_in   = rsp_blue_ff;
      rsp_green_in  = rsp_green_ff;
      rsp_red_in    = rsp_red_ff;
      rsp_status_in = rsp_status_ff;
      row_ext       = {5'd0, req_row};

      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_ROW_OFFSET: row_offset_in = csr_data[16:0];
            CSR_WEIGHT:     weight_in     = csr_data;
            CSR_DEPTH:      depth_in      = csr_data;
            default: ;
         endcase
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               op_in     = req_operation;
               disp_in   = req_disparity;
               row_in    = (row_ext >= 17'(ROW_LIMIT)) ? 12'(ROW_LIMIT - 1) : req_row;
               h_in      = '0;
               status_in = ST_OK;
               level_in  = '0;
               blue_in   = '0;
               green_in  = '0;
               red_in    = '0;
               if (req_operation == OP_FRAME) begin
                  min_in = '0;
                  max_in = '0;
               end
               if (req_operation == OP_MEASURE || req_operation == OP_COLOR) begin
                  state_in = S_PREP;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_PREP: begin
            num_in   = $signed({2'b00, row_ff, 4'b0000}) + 18'(row_offset_ff);
            prod_in  = 41'($signed({1'b0, disp_ff}) * weight_ff);
            state_in = S_DEN;
         end
         S_DEN: begin
            dzero_in = (md_w == '0);
            ovf_in   = ({20'd0, mn_w[16:0], 4'd0} >= md_w[40:0]);
            hneg_in  = (num_ff[17] == den_w[41]);
            state_in = div_cmd.start ? S_HDIV : S_HFIN;
         end
         S_HDIV: begin
            if (div_stat.done) begin
               state_in = S_HFIN;
            end
         end
         S_HFIN: begin
            priority if (disp_ff == '0) begin
               h_in      = '0;
               status_in = ST_NULL;
            end else if (dzero_ff) begin
               status_in = ST_ZERO_DEN;
               priority if (num_ff > 18'sd0) begin
                  h_in = HEIGHT_MIN;
               end else if (num_ff < 18'sd0) begin
                  h_in = HEIGHT_MAX;
               end else begin
                  h_in = '0;
               end
            end else begin
               status_in = ST_OK;
               priority if (ovf_ff) begin
                  h_in = hneg_ff ? HEIGHT_MIN : HEIGHT_MAX;
               end else if (hneg_ff) begin
                  h_in = q[23] ? HEIGHT_MIN : -$signed(q);
               end else begin
                  h_in = (q[23] || q[22:0] == '1) ? HEIGHT_MAX : $signed(q);
               end
            end
            if (op_ff == OP_MEASURE) begin
               if (disp_ff != '0) begin
                  if (h_in < min_ff) min_in = h_in;
                  if (h_in > max_ff) max_in = h_in;
               end
               state_in = S_DONE;
            end else begin
               state_in = S_LVL;
            end
         end
         S_LVL: begin
            range_in = range_w[23:0];
            p_in     = 39'(n_w[23:0]) * 39'(LEVEL_FULL);
            priority if (status_ff == ST_NULL || h_ff == '0) begin
               state_in = S_DONE;
            end else if (range_w == '0) begin
               // flat range: black, zero level
               if (status_ff == ST_OK) status_in = ST_FLAT;
               state_in = S_DONE;
            end else if (n_w[24] || n_w == '0) begin
               state_in = S_DONE;
            end else if (n_w[23:0] >= range_w[23:0]) begin
               // at or above max: clamp without dividing
               level_in = LEVEL_FULL;
               state_in = S_RSTART;
            end else begin
               state_in = S_LSTART;
            end
         end
         S_LSTART: begin
            state_in = S_LDIV;
         end
         S_LDIV: begin
            if (div_stat.done) begin
               level_in = q[LEVEL_W-1:0];
               state_in = S_RSTART;
            end
         end
         S_RSTART: begin
            state_in = S_RAMP;
         end
         S_RAMP: begin
            if (ramp_done) begin
               blue_in  = ramp_blue;
               green_in = ramp_green;
               red_in   = ramp_red;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_height_in = h_ff;
               rsp_level_in  = level_ff;
               rsp_blue_in   = blue_ff;
               rsp_green_in  = green_ff;
               rsp_red_in    = red_ff;
               rsp_status_in = status_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_valid_ff  <= 1'b0;
         row_offset_ff <= ROW_OFFSET_RST;
         weight_ff     <= WEIGHT_RST;
         depth_ff      <= DEPTH_RST;
         min_ff        <= '0;
         max_ff        <= '0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         row_offset_ff <= row_offset_in;
         weight_ff     <= weight_in;
         depth_ff      <= depth_in;
         min_ff        <= min_in;
         max_ff        <= max_in;
      end
      op_ff         <= op_in;
      disp_ff       <= disp_in;
      row_ff        <= row_in;
      num_ff        <= num_in;
      prod_ff       <= prod_in;
      dzero_ff      <= dzero_in;
      ovf_ff        <= ovf_in;
      hneg_ff       <= hneg_in;
      h_ff          <= h_in;
      status_ff     <= status_in;
      level_ff      <= level_in;
      p_ff          <= p_in;
      range_ff      <= range_in;
      blue_ff       <= blue_in;
      green_ff      <= green_in;
      red_ff        <= red_in;
      rsp_height_ff <= rsp_height_in;
      rsp_level_ff  <= rsp_level_in;
      rsp_blue_ff   <= rsp_blue_in;
      rsp_green_ff  <= rsp_green_in;
      rsp_red_ff    <= rsp_red_in;
      rsp_status_ff <= rsp_status_in;
   end

   dhh_div u_div (
      .clock    (clock),
      .reset    (reset),
      .cmd      (div_cmd),
      .rem_init (div_rem_init),
      .low_init (div_low_init),
      .divisor  (div_divisor),
      .stat     (div_stat),
      .quotient (div_quo)
   );

   dhh_ramp u_ramp (
      .clock (clock),
      .reset (reset),
      .start (state_ff == S_RSTART),
      .level (level_ff),
      .done  (ramp_done),
      .blue  (ramp_blue),
      .green (ramp_green),
      .red   (ramp_red)
   );

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_height = rsp_height_ff;
   assign rsp_level  = rsp_level_ff;
   assign rsp_blue   = rsp_blue_ff;
   assign rsp_green  = rsp_green_ff;
   assign rsp_red    = rsp_red_ff;
   assign rsp_status = rsp_status_ff;

   // min never rises above zero, max never drops below it
   `DHH_ASSERT(a_extremes_bracket_zero, clock, reset, (min_ff <= 24'sd0) && (max_ff >= 24'sd0), "frame extremes do not bracket zero")
   `DHH_ASSERT_IMPLY(a_level_bound, clock, reset, rsp_valid_ff, rsp_level_ff <= LEVEL_FULL, "level above full scale")
   `DHH_ASSERT_IMPLY(a_flat_black, clock, reset, rsp_valid_ff && rsp_status_ff == ST_FLAT, rsp_level_ff == '0 && rsp_blue_ff == '0 && rsp_green_ff == '0 && rsp_red_ff == '0, "flat range response not black")

endmodule
